// ----- design/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros shared by the top-k list modules.
// Each macro samples on the rising edge of clk. It is turned off while rst is high.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/bsit_pkg.sv -----
// ---------------------------------------------------------------------------
// bsit_pkg
// Types, field widths and codes shared by the top-k sorted list modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bsit_pkg;

  // Default number of list slots that are built.
  localparam int DEPTH_DEF = 16;

  // Field widths of the item channels.
  localparam int KEY_W   = 32;
  localparam int PAY_W   = 32;
  localparam int MODE_W  = 2;
  localparam int INDEX_W = 4;
  localparam int POS_W   = 5;
  localparam int CAP_W   = 5;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ORDER    = 1'b1;

  // Operation codes carried in the mode field.
  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_READ   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

  // One input item.
  typedef struct packed {
    logic [MODE_W-1:0]        mode;
    logic signed [KEY_W-1:0]  key;
    logic [PAY_W-1:0]         payload;
    logic [INDEX_W-1:0]       index;
  } cmd_item_t;

  // One result item.
  typedef struct packed {
    logic                     inserted;
    logic [POS_W-1:0]         position;
    logic                     evicted;
    logic [POS_W-1:0]         count;
    logic                     read_valid;
    logic signed [KEY_W-1:0]  read_key;
    logic [PAY_W-1:0]         read_payload;
  } res_item_t;

  // One stored list entry.
  typedef struct packed {
    logic signed [KEY_W-1:0]  key;
    logic [PAY_W-1:0]         payload;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;       // latch the input item and restart the scan pointer
    logic rd_scan;      // read the entry at the scan pointer
    logic scan_step;    // advance the scan pointer
    logic shift_init;   // load the shift pointer with the last slot
    logic rd_shift;     // read the entry just above the shift pointer
    logic shift_write;  // move the read entry down one slot
    logic place_write;  // write the new entry at the insertion slot
    logic rd_index;     // read the entry named by the read item
    logic load_result;  // load the result register
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_end;     // scan pointer reached the entry count
    logic ahead;        // entry just read ranks ahead of the new key
    logic fits;         // insertion slot lies inside the capacity
    logic shift_end;    // shift pointer reached the insertion slot
    logic res_free;     // result register can take a new item
  } dp_status_t;

endpackage

`default_nettype wire

// ----- design/bounded_sorted_insert_topk.sv -----
// ---------------------------------------------------------------------------
// bounded_sorted_insert_topk
// Bounded sorted key/payload list with insert, read-by-index and clear.
// ---------------------------------------------------------------------------
// The block works on one item at a time. All list entries sit in a single
// memory with one write port and one registered read port, so every step
// touches one entry. A read passes a read state and a done state, a clear
// or an unused mode goes straight to the done state. An insert scans with a
// scan and a compare state per entry, moves each entry from the insertion
// slot on down one slot with a shift and a move state, and then writes the
// new entry in the insertion slot. A full list still moves only up to its
// last slot. The result waits in an output register, and the next item is
// taken once it is loaded there. The memory needs no clearing after reset.
`timescale 1ns / 1ps
`default_nettype none

module bounded_sorted_insert_topk #(
  parameter int DEPTH = bsit_pkg::DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cmd_valid,
  output logic                              cmd_stall,
  input  bsit_pkg::cmd_item_t               cmd,
  output logic                              res_valid,
  input  logic                              res_stall,
  output bsit_pkg::res_item_t               res,
  input  logic                              cfg_we,
  input  logic [bsit_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bsit_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import bsit_pkg::*;

  ctrl_cmd_t  ctl;
  dp_status_t sts;

  // Sequencer for the phases of one item.
  bsit_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .mode      (cmd.mode),
    .sts       (sts),
    .ctl       (ctl)
  );

  // Entry storage, compare and result register.
  bsit_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .ctl       (ctl),
    .sts       (sts),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule

`default_nettype wire

// ----- design/bsit_dp.sv -----
// ---------------------------------------------------------------------------
// bsit_dp
// Datapath of the top-k list: entry memory, pointers, count and capacity
// registers, key comparator and the result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module bsit_dp #(
  parameter int DEPTH = bsit_pkg::DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [bsit_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bsit_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  bsit_pkg::cmd_item_t               cmd,
  input  bsit_pkg::ctrl_cmd_t               ctl,
  output bsit_pkg::dp_status_t              sts,
  output logic                              res_valid,
  input  logic                              res_stall,
  output bsit_pkg::res_item_t               res
);
  import bsit_pkg::*;

  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int CAP_RST = (DEPTH < 16) ? DEPTH : 16;

  entry_t              mem [DEPTH];
  entry_t              rdata;
  cmd_item_t           item;
  logic [CNT_W-1:0]    ptr;
  logic [IDX_W-1:0]    j;
  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    cap;
  logic                desc;
  logic                evict;
  logic [CNT_W-1:0]    cap_new;
  logic [CMP_W-1:0]    cap_ext;
  logic [IDX_W-1:0]    raddr;
  logic                rd_en;
  logic [IDX_W-1:0]    waddr;
  entry_t              wdata;
  logic                wr_en;
  logic [IDX_W-1:0]    last;
  logic                read_ok;
  res_item_t           res_next;

  // Effective capacity for a register write: zero acts as one, the top is the depth.
  always_comb begin
    cap_ext = CMP_W'(cfg_data[CAP_W-1:0]);
    if (cap_ext == '0) begin
      cap_new = CNT_W'(1);
    end else if (cap_ext > CMP_W'(DEPTH)) begin
      cap_new = CNT_W'(DEPTH);
    end else begin
      cap_new = CNT_W'(cap_ext);
    end
  end

  // Capacity and order registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cap  <= CNT_W'(CAP_RST);
      desc <= 1'b1;
    end else if (cfg_we) begin
      if (cfg_index == REG_CAPACITY) begin
        cap <= cap_new;
      end else begin
        desc <= cfg_data[0];
      end
    end
  end

  // Status toward the controller.
  always_comb begin
    sts.scan_end  = (ptr == count);
    sts.ahead     = desc ? (rdata.key > item.key) : (rdata.key < item.key);
    sts.fits      = (ptr < cap);
    sts.shift_end = (CNT_W'(j) == ptr);
    sts.res_free  = !res_valid || !res_stall;
  end

  // Last slot touched by the shift: the first free slot, or the tail of a full list.
  assign last = (count < cap) ? IDX_W'(count) : IDX_W'(cap - CNT_W'(1));

  // Input item, scan pointer, shift pointer and eviction flag.
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      item <= cmd;
      ptr  <= '0;
    end else if (ctl.scan_step) begin
      ptr <= ptr + CNT_W'(1);
    end
    if (ctl.shift_init) begin
      j     <= last;
      evict <= (count == cap);
    end else if (ctl.shift_write) begin
      j <= j - IDX_W'(1);
    end
  end

  // Entry count: clear, growth on insert, cut on a lowered capacity.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.load_result && item.mode == MODE_CLEAR) begin
      count <= '0;
    end else if (ctl.place_write && count < cap) begin
      count <= count + CNT_W'(1);
    end else if (cfg_we && cfg_index == REG_CAPACITY && count > cap_new) begin
      count <= cap_new;
    end
  end

  // Memory port selection.
  always_comb begin
    rd_en = ctl.rd_scan || ctl.rd_shift || ctl.rd_index;
    priority if (ctl.rd_shift) begin
      raddr = j - IDX_W'(1);
    end else if (ctl.rd_index) begin
      raddr = IDX_W'(item.index);
    end else begin
      raddr = IDX_W'(ptr);
    end
    wr_en = ctl.shift_write || ctl.place_write;
    if (ctl.shift_write) begin
      waddr = j;
      wdata = rdata;
    end else begin
      waddr = IDX_W'(ptr);
      wdata = '{key: item.key, payload: item.payload};
    end
  end

  // Entry memory with a registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata <= mem[raddr];
    end
  end

  // Result fields for the item that just finished.
  assign read_ok = (CMP_W'(item.index) < CMP_W'(count));

  always_comb begin
    res_next       = '0;
    res_next.count = POS_W'(count);
    unique case (item.mode)
      MODE_INSERT: begin
        res_next.inserted = sts.fits;
        res_next.position = sts.fits ? POS_W'(ptr) : POS_W'(cap);
        res_next.evicted  = sts.fits && evict;
      end
      MODE_READ: begin
        res_next.read_valid = read_ok;
        if (read_ok) begin
          res_next.read_key     = rdata.key;
          res_next.read_payload = rdata.payload;
        end
      end
      MODE_CLEAR: begin
        res_next.count = '0;
      end
      default: begin
        res_next.count = POS_W'(count);
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (ctl.load_result) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
    if (ctl.load_result) begin
      res <= res_next;
    end
  end

  `ASSERT_ALWAYS(a_count_in_cap, count <= cap, "entry count exceeds capacity")
  `ASSERT_IMPLY(a_move_below_slot, ctl.shift_write, CNT_W'(j) > ptr, "move at or above slot")
  `ASSERT_NEXT(a_place_grows, ctl.place_write && count < cap, count == $past(count) + CNT_W'(1), "count did not grow")

endmodule

`default_nettype wire

// ----- design/bsit_ctrl.sv -----
// ---------------------------------------------------------------------------
// bsit_ctrl
// Controller of the top-k list: steps the scan, shift, read and result
// phases of one item at a time.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module bsit_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  output logic                          cmd_stall,
  input  logic [bsit_pkg::MODE_W-1:0]   mode,
  input  bsit_pkg::dp_status_t          sts,
  output bsit_pkg::ctrl_cmd_t           ctl
);
  import bsit_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_SCAN    = 7'b0000010,
    S_COMPARE = 7'b0000100,
    S_SHIFT   = 7'b0001000,
    S_MOVE    = 7'b0010000,
    S_READ    = 7'b0100000,
    S_DONE    = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Only an idle controller takes a new item.
  assign cmd_stall = (state != S_IDLE);

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    ctl        = '0;
    unique case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          ctl.accept = 1'b1;
          unique case (mode)
            MODE_INSERT: state_next = S_SCAN;
            MODE_READ:   state_next = S_READ;
            default:     state_next = S_DONE;
          endcase
        end
      end
      S_SCAN: begin
        if (!sts.scan_end) begin
          ctl.rd_scan = 1'b1;
          state_next  = S_COMPARE;
        end else if (sts.fits) begin
          ctl.shift_init = 1'b1;
          state_next     = S_SHIFT;
        end else begin
          state_next = S_DONE;
        end
      end
      S_COMPARE: begin
        if (sts.ahead) begin
          ctl.scan_step = 1'b1;
          state_next    = S_SCAN;
        end else if (sts.fits) begin
          ctl.shift_init = 1'b1;
          state_next     = S_SHIFT;
        end else begin
          state_next = S_DONE;
        end
      end
      S_SHIFT: begin
        if (sts.shift_end) begin
          ctl.place_write = 1'b1;
          state_next      = S_DONE;
        end else begin
          ctl.rd_shift = 1'b1;
          state_next   = S_MOVE;
        end
      end
      S_MOVE: begin
        ctl.shift_write = 1'b1;
        state_next      = S_SHIFT;
      end
      S_READ: begin
        ctl.rd_index = 1'b1;
        state_next   = S_DONE;
      end
      S_DONE: begin
        if (sts.res_free) begin
          ctl.load_result = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `ASSERT_NEXT(a_insert_scans, cmd_valid && !cmd_stall && mode == MODE_INSERT, state == S_SCAN, "insert did not start a scan")
  `ASSERT_NEXT(a_move_returns, state == S_MOVE, state == S_SHIFT, "move did not return to shift")

endmodule

`default_nettype wire
